### sv/swlpd_pkg.sv
// ----------------------------------------------------------------------------
// swlpd_pkg: shared types and constants for the sync word deframer
// Holds the parse mode encoding, the result beat layout and the register
// indexes and reset values of the configuration port.
// ----------------------------------------------------------------------------
package swlpd_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_PATTERN    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD_LEN = 1'b1;

   // Register reset values: the sync word is "Z0R0".
   localparam logic [31:0] SYNC_PATTERN_RESET    = 32'h5A30_5230;
   localparam logic [30:0] MAX_PAYLOAD_LEN_RESET = 31'd65536;

   // Number of bytes in the sync window, and the index of the last length byte.
   localparam logic [2:0] WINDOW_BYTES = 3'd4;
   localparam logic [1:0] LEN_LAST_IDX = 2'd3;

   // Parse modes. The unused code behaves as hunt.
   typedef enum logic [1:0] {
      MODE_HUNT = 2'd0,
      MODE_LEN  = 2'd1,
      MODE_DATA = 2'd2
   } mode_type;

   // One result beat.
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_of_frame;
      logic       empty_frame;
      logic       oversize_error;
   } rsp_type;

endpackage

### sv/sync_word_length_prefixed_deframer.sv
// ----------------------------------------------------------------------------
// sync_word_length_prefixed_deframer: byte stream deframer
// Hunts for a 4-byte sync word, reads a 4-byte big-endian length and passes
// the payload bytes out, marking the last one, an empty frame or an
// oversize frame.
//
// Usage:
//   req_ channel: one received byte per beat (req_rx_byte).
//   rsp_ channel: one result beat per payload byte, plus one beat for an
//   empty frame or an oversize length. Sync and length bytes give no beat.
//   csr_ port: writes the sync pattern (index 0) and the maximum payload
//   length (index 1), taken in the cycle csr_we is high.
// Output: a result is on rsp_ the cycle after its byte is accepted when the
// main output register is free, and waits in the skid entry otherwise.
// Throughput: one byte per cycle while req_ready is high; the parse state
// updates in the accept cycle. req_ready drops once both entries of the
// two-entry output buffer are full and rises again once a beat is taken.
// Reset clears the parse state to hunt with an empty window, empties the
// output buffer and loads "Z0R0" and 65536 into the registers.
// ----------------------------------------------------------------------------
module sync_word_length_prefixed_deframer
   import swlpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_last_of_frame,
   output logic                   rsp_empty_frame,
   output logic                   rsp_oversize_error,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [31:0] sync_pattern_ff;
   logic [30:0] max_len_ff;
   logic        accept;
   logic        result_valid;
   rsp_type     result;
   rsp_type     rsp_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_pattern_ff <= SYNC_PATTERN_RESET;
         max_len_ff      <= MAX_PAYLOAD_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_PATTERN:    sync_pattern_ff <= csr_wdata;
            CSR_MAX_PAYLOAD_LEN: max_len_ff      <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign accept = req_valid && req_ready;

   // Parse state and result generation.
   swlpd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .rx_byte         (req_rx_byte),
      .sync_pattern    (sync_pattern_ff),
      .max_payload_len (max_len_ff),
      .result_valid    (result_valid),
      .result          (result)
   );

   // Result register and skid stage.
   swlpd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .space     (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_last_of_frame  = rsp_data.last_of_frame;
   assign rsp_empty_frame    = rsp_data.empty_frame;
   assign rsp_oversize_error = rsp_data.oversize_error;

endmodule

### sv/swlpd_parser.sv
// ----------------------------------------------------------------------------
// swlpd_parser: sync hunt, length gathering and payload counting
// Updates the parse state for every accepted byte and produces the result
// beat that the byte causes, if any, in the same cycle.
// ----------------------------------------------------------------------------
module swlpd_parser
   import swlpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  rx_byte,
   input  logic [31:0] sync_pattern,
   input  logic [30:0] max_payload_len,
   output logic        result_valid,
   output rsp_type     result
);

   mode_type    mode_ff,      mode_in;
   logic [31:0] window_ff,    window_in;
   logic [2:0]  fill_ff,      fill_in;
   logic [31:0] len_ff,       len_in;
   logic [1:0]  len_seen_ff,  len_seen_in;
   logic [30:0] remaining_ff, remaining_in;

   logic [31:0] window_shift;
   logic [2:0]  fill_inc;
   logic [31:0] len_shift;
   logic [30:0] remaining_dec;

   // Shared datapath terms.
   always_comb begin
      window_shift  = {window_ff[23:0], rx_byte};
      fill_inc      = (fill_ff < WINDOW_BYTES) ? fill_ff + 3'd1 : WINDOW_BYTES;
      len_shift     = {len_ff[23:0], rx_byte};
      remaining_dec = (remaining_ff != 31'd0) ? remaining_ff - 31'd1 : 31'd0;
   end

   // Next state and result for the byte at hand.
   always_comb begin
      mode_in      = mode_ff;
      window_in    = window_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      len_seen_in  = len_seen_ff;
      remaining_in = remaining_ff;
      result_valid = 1'b0;
      result       = '0;
      if (accept) begin
         case (mode_ff)
            MODE_LEN: begin
               len_in = len_shift;
               if (len_seen_ff != LEN_LAST_IDX) begin
                  len_seen_in = len_seen_ff + 2'd1;
               end else begin
                  len_seen_in = 2'd0;
                  if (len_shift == 32'd0) begin
                     // Empty frame: one marker beat, then hunt again.
                     mode_in              = MODE_HUNT;
                     window_in            = '0;
                     fill_in              = '0;
                     result_valid         = 1'b1;
                     result.last_of_frame = 1'b1;
                     result.empty_frame   = 1'b1;
                  end else if (len_shift > {1'b0, max_payload_len}) begin
                     // Oversize frame: flag it and drop the payload.
                     mode_in               = MODE_HUNT;
                     window_in             = '0;
                     fill_in               = '0;
                     result_valid          = 1'b1;
                     result.last_of_frame  = 1'b1;
                     result.oversize_error = 1'b1;
                  end else begin
                     remaining_in = len_shift[30:0];
                     mode_in      = MODE_DATA;
                  end
               end
            end
            MODE_DATA: begin
               remaining_in         = remaining_dec;
               result_valid         = 1'b1;
               result.payload_byte  = rx_byte;
               result.last_of_frame = (remaining_dec == 31'd0);
               if (remaining_dec == 31'd0) begin
                  mode_in   = MODE_HUNT;
                  window_in = '0;
                  fill_in   = '0;
               end
            end
            default: begin
               // Hunt, also taken for the unused mode code.
               mode_in   = MODE_HUNT;
               window_in = window_shift;
               fill_in   = fill_inc;
               if (fill_inc == WINDOW_BYTES && window_shift == sync_pattern) begin
                  mode_in     = MODE_LEN;
                  len_in      = '0;
                  len_seen_in = '0;
               end
            end
         endcase
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_HUNT;
         window_ff    <= '0;
         fill_ff      <= '0;
         len_ff       <= '0;
         len_seen_ff  <= '0;
         remaining_ff <= '0;
      end else begin
         mode_ff      <= mode_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         len_seen_ff  <= len_seen_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

### sv/swlpd_out_buf.sv
// ----------------------------------------------------------------------------
// swlpd_out_buf: result register with a skid stage
// Holds up to two result beats so that the input side can still take a
// byte while the receiver stalls.
// ----------------------------------------------------------------------------
module swlpd_out_buf
   import swlpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff,       main_in;
   rsp_type skid_ff,       skid_in;
   logic    main_free;

   // The main register can load when it is empty or being drained.
   assign main_free = !main_valid_ff || rsp_ready;

   // Next contents of both stages. A push only arrives while the skid is empty.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (main_free) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_free) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (main_free) begin
         main_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Beat storage.
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign space     = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

### tb/sv/deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker: result predictor and comparator for the deframer
// Watches the byte, result and register ports. It keeps its own copy of the
// parse state and the registers, works out the result beat that each
// accepted byte causes, and compares every result beat, field by field,
// with the oldest one still due. It reports the number of mismatches and
// the number of beats still due.
// ----------------------------------------------------------------------------
module deframer_checker
   import swlpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [7:0]             rsp_payload_byte,
   input  logic                   rsp_last_of_frame,
   input  logic                   rsp_empty_frame,
   input  logic                   rsp_oversize_error,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     beats_outstanding
);

   // Predicted parse state and register copies.
   mode_type    mode;
   logic [31:0] window;
   logic [2:0]  fill;
   logic [31:0] len_accum;
   logic [1:0]  len_seen;
   logic [30:0] remaining;
   logic [31:0] sync_word;
   logic [30:0] max_len;

   // Result beats predicted but not yet seen on the result channel.
   rsp_type beats_due[$];

   task automatic report_mismatch(input string line);
      $display("ERROR at %0t: %s", $time, line);
      mismatch_count++;
   endtask

   task automatic queue_beat(input logic [7:0] data, input logic last,
                             input logic empty, input logic oversize);
      rsp_type beat;
      beat.payload_byte   = data;
      beat.last_of_frame  = last;
      beat.empty_frame    = empty;
      beat.oversize_error = oversize;
      beats_due.push_back(beat);
   endtask

   task automatic restart_hunt();
      mode   = MODE_HUNT;
      window = '0;
      fill   = '0;
   endtask

   // Advance the predicted parse state by one received byte.
   task automatic deframe_byte(input logic [7:0] rx);
      case (mode)
         MODE_LEN: begin
            len_accum = {len_accum[23:0], rx};
            if (len_seen != LEN_LAST_IDX) begin
               len_seen++;
            end else begin
               len_seen = '0;
               if (len_accum == 32'd0) begin
                  restart_hunt();
                  queue_beat(8'h00, 1'b1, 1'b1, 1'b0);
               end else if (len_accum > {1'b0, max_len}) begin
                  // Lengths with the top bit set always land here.
                  restart_hunt();
                  queue_beat(8'h00, 1'b1, 1'b0, 1'b1);
               end else begin
                  remaining = len_accum[30:0];
                  mode      = MODE_DATA;
               end
            end
         end
         MODE_DATA: begin
            if (remaining != '0) remaining--;
            if (remaining == '0) begin
               restart_hunt();
               queue_beat(rx, 1'b1, 1'b0, 1'b0);
            end else begin
               queue_beat(rx, 1'b0, 1'b0, 1'b0);
            end
         end
         default: begin
            // Hunt; the unused mode code behaves the same way.
            mode   = MODE_HUNT;
            window = {window[23:0], rx};
            if (fill < WINDOW_BYTES) fill++;
            if (fill >= WINDOW_BYTES && window == sync_word) begin
               mode      = MODE_LEN;
               len_accum = '0;
               len_seen  = '0;
            end
         end
      endcase
   endtask

   // Sample all channels at the rising edge.
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         mode           = MODE_HUNT;
         window         = '0;
         fill           = '0;
         len_accum      = '0;
         len_seen       = '0;
         remaining      = '0;
         sync_word      = SYNC_PATTERN_RESET;
         max_len        = MAX_PAYLOAD_LEN_RESET;
         mismatch_count = 0;
         beats_due.delete();
      end else begin
         // Compare a delivered result beat with the oldest one due.
         if (rsp_valid && rsp_ready) begin
            if (beats_due.size() == 0) begin
               report_mismatch($sformatf("result beat 0x%02h with none due",
                                         rsp_payload_byte));
            end else begin
               want = beats_due.pop_front();
               if (rsp_payload_byte !== want.payload_byte)
                  report_mismatch($sformatf("payload_byte 0x%02h, expected 0x%02h",
                                            rsp_payload_byte, want.payload_byte));
               if (rsp_last_of_frame !== want.last_of_frame)
                  report_mismatch($sformatf("last_of_frame %b, expected %b",
                                            rsp_last_of_frame, want.last_of_frame));
               if (rsp_empty_frame !== want.empty_frame)
                  report_mismatch($sformatf("empty_frame %b, expected %b",
                                            rsp_empty_frame, want.empty_frame));
               if (rsp_oversize_error !== want.oversize_error)
                  report_mismatch($sformatf("oversize_error %b, expected %b",
                                            rsp_oversize_error, want.oversize_error));
            end
         end
         // Register writes.
         if (csr_we) begin
            case (csr_index)
               CSR_SYNC_PATTERN:    sync_word = csr_wdata;
               CSR_MAX_PAYLOAD_LEN: max_len   = csr_wdata[30:0];
               default: ;
            endcase
         end
         // Accepted input beat.
         if (req_valid && req_ready) deframe_byte(req_rx_byte);
      end
      beats_outstanding = beats_due.size();
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the sync word deframer
// Drives a byte stream of frames, noise and cut-short sync words with random
// gaps on both channels, rewrites the registers between phases (extremes
// included), forces one long result stall, and reports the verdict from
// the mismatch count of the checker.
// ----------------------------------------------------------------------------
module testbench
   import swlpd_pkg::*;
();

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_rx_byte;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [7:0]             rsp_payload_byte;
   logic                   rsp_last_of_frame;
   logic                   rsp_empty_frame;
   logic                   rsp_oversize_error;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatch_count;
   int beats_outstanding;

   // Gap limits per side, and long-stall requests to the receiver.
   int tx_idle_max;
   int rx_idle_max;
   int holds_asked;
   int holds_done;
   int bytes_sent;

   // Register values as last written, used to shape frames.
   logic [31:0] sync_now;
   logic [30:0] max_len_now;

   sync_word_length_prefixed_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_empty_frame    (rsp_empty_frame),
      .rsp_oversize_error (rsp_oversize_error),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   deframer_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_empty_frame    (rsp_empty_frame),
      .rsp_oversize_error (rsp_oversize_error),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .beats_outstanding  (beats_outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offer one byte after a random gap and hold it until accepted.
   // Called and returns at a falling edge.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = $urandom_range(0, tx_idle_max);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Four bytes, most significant first.
   task automatic send_word(input logic [31:0] value);
      for (int i = 3; i >= 0; i--) send_byte(value[8*i +: 8]);
   endtask

   // Stop offering and wait until every due result beat has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      while (beats_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register write; only used while the block is idle.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_SYNC_PATTERN) sync_now = value;
      else max_len_now = value[30:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // A byte equal to none of the sync bytes, so that noise can never form
   // or complete a sync word and shift the framing.
   function automatic logic [7:0] off_sync_byte();
      logic [7:0] b;
      b = 8'($urandom);
      while (b == sync_now[31:24] || b == sync_now[23:16] ||
             b == sync_now[15:8] || b == sync_now[7:0])
         b = 8'($urandom);
      return b;
   endfunction

   // One frame with random content, sometimes led by noise, or a sync word
   // cut short by a stray byte.
   task automatic send_random_frame();
      int          noise;
      int          prefix;
      int          pick;
      logic [31:0] len;
      noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      repeat (noise) send_byte(off_sync_byte());
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         prefix = $urandom_range(1, 3);
         for (int i = 0; i < prefix; i++) send_byte(sync_now[31 - 8*i -: 8]);
         send_byte(off_sync_byte());
      end else begin
         if (pick < 18) begin
            len = 32'd0;
         end else if (pick < 30) begin
            // Oversize: just above the limit, well above, or top bit set.
            case ($urandom_range(0, 3))
               0:       len = {1'b0, max_len_now} + 32'd1;
               1:       len = {1'b0, max_len_now} + $urandom_range(1, 1000);
               2:       len = $urandom | 32'h8000_0000;
               default: len = 32'hFFFF_FFFF;
            endcase
         end else if (pick < 36 && max_len_now <= 31'd40) begin
            len = {1'b0, max_len_now};
         end else if (pick < 42) begin
            len = $urandom_range(13, 64);
         end else begin
            len = $urandom_range(1, 12);
         end
         send_word(sync_now);
         send_word(len);
         if (len != 32'd0 && len <= {1'b0, max_len_now})
            repeat (len) send_byte(8'($urandom));
      end
   endtask

   // Result side: a random gap before each beat, or a long stall on request.
   initial begin : sink
      int gap;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (holds_done != holds_asked) begin
            holds_done++;
            gap = 60;
         end else begin
            gap = $urandom_range(0, rx_idle_max);
         end
         repeat (gap) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin : stimulus
      int phase;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      csr_we      = 1'b0;
      csr_index   = CSR_SYNC_PATTERN;
      csr_wdata   = '0;
      tx_idle_max = 0;
      rx_idle_max = 2;
      holds_asked = 0;
      holds_done  = 0;
      bytes_sent  = 0;
      sync_now    = SYNC_PATTERN_RESET;
      max_len_now = MAX_PAYLOAD_LEN_RESET;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty frame, one-byte frame, length with the top bit set.
      send_word(sync_now);
      send_word(32'd0);
      send_word(sync_now);
      send_word(32'd1);
      send_byte(8'hFF);
      send_word(sync_now);
      send_word(32'h8000_0000);
      drain();

      // Random phases, each with its own registers and gap limits.
      for (phase = 0; bytes_sent < 1350; phase++) begin
         case (phase)
            0: ;
            1: write_csr(CSR_MAX_PAYLOAD_LEN, 32'd0);
            2: begin
               write_csr(CSR_SYNC_PATTERN, 32'h0000_0000);
               write_csr(CSR_MAX_PAYLOAD_LEN, 32'hFFFF_FFFF);
            end
            3: write_csr(CSR_SYNC_PATTERN, 32'hFFFF_FFFF);
            4: begin
               write_csr(CSR_SYNC_PATTERN, $urandom);
               write_csr(CSR_MAX_PAYLOAD_LEN, $urandom_range(1, 16));
            end
            default: begin
               write_csr(CSR_SYNC_PATTERN, $urandom);
               write_csr(CSR_MAX_PAYLOAD_LEN,
                         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40));
            end
         endcase

         // Long result stall while bytes keep coming, so the input backs up.
         if (phase == 0) begin
            tx_idle_max = 0;
            rx_idle_max = 0;
            send_word(sync_now);
            send_word(32'd48);
            holds_asked++;
            repeat (48) send_byte(8'($urandom));
         end

         tx_idle_max = 4 * $urandom_range(0, 4);
         rx_idle_max = 4 * $urandom_range(0, 4);
         repeat (12) send_random_frame();
         drain();
      end

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog for a hung handshake or beats that never arrive.
   initial begin : watchdog
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
